// ===== rtl/core/ecu_pkg.sv =====
// Package for the elementwise combine unit: types, constants and rounding helper.
`timescale 1ns / 1ps
package ecu_pkg;

  localparam int DATA_W    = 16;
  localparam int NUM_LANES = 4;
  localparam int FRAC_W    = 8;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int Q_W       = SUM_W + 1 - FRAC_W;
  localparam int N_W       = 3;
  localparam int CFG_IDX_W = 3;
  localparam int PIPE_D    = 6;

  localparam logic [N_W-1:0] N_MIN = N_W'(2);
  localparam logic [N_W-1:0] N_MAX = N_W'(NUM_LANES);

  localparam logic signed [DATA_W-1:0] COEFF_ONE = DATA_W'(1 << FRAC_W);
  localparam logic signed [DATA_W-1:0] DATA_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_PROD = 2'd0,
    MODE_SUM  = 2'd1,
    MODE_MAX  = 2'd2,
    MODE_BAD  = 2'd3
  } op_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OP_MODE    = 3'd0,
    REG_NUM_INPUTS = 3'd1,
    REG_COEFF_A    = 3'd2,
    REG_COEFF_B    = 3'd3,
    REG_COEFF_C    = 3'd4,
    REG_COEFF_D    = 3'd5
  } cfg_reg_t;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] elem_a;
    logic signed [DATA_W-1:0] elem_b;
    logic signed [DATA_W-1:0] elem_c;
    logic signed [DATA_W-1:0] elem_d;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] combined;
    logic                     clipped;
    logic                     bad_mode;
  } out_beat_t;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } res_t;

  typedef struct packed {
    op_mode_t       mode;
    logic [N_W-1:0] n;
  } ctrl_t;

  // Q18.16 -> Q8.8: add half, floor, saturate.
  function automatic res_t round_sat(input sum_t v);
    logic signed [SUM_W:0] t;
    logic signed [Q_W-1:0] q;
    logic                  ovf;
    res_t                  r;
    t   = (SUM_W+1)'(v) + (SUM_W+1)'(1 << (FRAC_W - 1));
    q   = t[SUM_W:FRAC_W];
    ovf = !((&q[Q_W-1:DATA_W-1]) || !(|q[Q_W-1:DATA_W-1]));
    r.clip = ovf;
    if (ovf) begin
      r.val = q[Q_W-1] ? DATA_MIN : DATA_MAX;
    end else begin
      r.val = q[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/eltwise_combine_unit_top.sv =====
// Elementwise combine unit: product, weighted sum or maximum of up to four Q8.8 inputs.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one beat per tensor position
//   holding elem_a..elem_d. Result channel (out_valid/out_stall/out_data) returns one
//   beat per input beat, in order: combined value, clipped flag, bad_mode flag.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes op_mode,
//   num_inputs and coeff_a..coeff_d; write it only while the unit is idle.
// Throughput: one beat per cycle, sustained while in_stall is low.
// Depth: set by the product chain, three 16x16 multiplies each followed by a
//   round/saturate stage.
// Reset: pipeline and output emptied; op_mode = weighted sum, num_inputs = 2,
//   all coefficients = 1.0.
// Stall: a result held on out_stall stays put; the pipeline keeps moving into a
//   one-beat skid buffer, and in_stall rises only once that buffer is full.
`timescale 1ns / 1ps
module eltwise_combine_unit_top
  import ecu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  op_mode_t       op_mode_r;
  logic [N_W-1:0] num_inputs_r;
  data_t          coeff_r [NUM_LANES];

  logic [N_W-1:0]       n_eff;
  logic                 en;
  logic [PIPE_D-1:0]    vld_r;
  ctrl_t                ctl_r [PIPE_D];
  data_t                elem_in [NUM_LANES];
  prod_t                lane_prod [NUM_LANES];
  data_t                lane_elem [NUM_LANES];
  logic [NUM_LANES-1:0] lane_act;
  out_beat_t            merge_beat;
  out_beat_t            dly_r [3];
  res_t                 chain_res;
  out_beat_t            final_beat;
  out_beat_t            out_r, skid_r;
  logic                 out_vld_r, skid_full_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r    <= MODE_SUM;
      num_inputs_r <= N_MIN;
      for (int i = 0; i < NUM_LANES; i++) begin
        coeff_r[i] <= COEFF_ONE;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OP_MODE:    op_mode_r    <= op_mode_t'(cfg_data[1:0]);
        REG_NUM_INPUTS: num_inputs_r <= cfg_data[N_W-1:0];
        REG_COEFF_A:    coeff_r[0]   <= cfg_data;
        REG_COEFF_B:    coeff_r[1]   <= cfg_data;
        REG_COEFF_C:    coeff_r[2]   <= cfg_data;
        REG_COEFF_D:    coeff_r[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_inputs_r < N_MIN) begin
      n_eff = N_MIN;
    end else if (num_inputs_r > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = num_inputs_r;
    end
  end

  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  assign elem_in[0] = in_data.elem_a;
  assign elem_in[1] = in_data.elem_b;
  assign elem_in[2] = in_data.elem_c;
  assign elem_in[3] = in_data.elem_d;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    ecu_lane u_lane (
      .clk      (clk),
      .en       (en),
      .active   (N_W'(g) < n_eff),
      .coeff    (coeff_r[g]),
      .elem     (elem_in[g]),
      .wprod_r  (lane_prod[g]),
      .elem_r   (lane_elem[g]),
      .active_r (lane_act[g])
    );
  end

  ecu_merge u_merge (
    .clk    (clk),
    .en     (en),
    .mode   (ctl_r[0].mode),
    .wprod  (lane_prod),
    .elem   (lane_elem),
    .active (lane_act),
    .beat_r (merge_beat)
  );

  ecu_prod_chain u_chain (
    .clk     (clk),
    .en      (en),
    .in_beat (in_data),
    .n       (n_eff),
    .res_r   (chain_res)
  );

  // Pipeline valid/control; merge beat is ready at stage 3 and waits for the chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_D-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= '{mode: op_mode_r, n: n_eff};
      for (int i = 1; i < PIPE_D; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
      dly_r[0] <= merge_beat;
      dly_r[1] <= dly_r[0];
      dly_r[2] <= dly_r[1];
    end
  end

  always_comb begin
    final_beat = dly_r[2];
    if (ctl_r[PIPE_D-1].mode == MODE_PROD) begin
      final_beat.combined = chain_res.val;
      final_beat.clipped  = chain_res.clip;
      final_beat.bad_mode = 1'b0;
    end
  end

  // Output register plus one-beat skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (!out_stall) begin
        out_r       <= skid_r;
        skid_full_r <= 1'b0;
      end
    end else if (!out_vld_r || !out_stall) begin
      out_vld_r <= vld_r[PIPE_D-1];
      if (vld_r[PIPE_D-1]) begin
        out_r <= final_beat;
      end
    end else if (vld_r[PIPE_D-1]) begin
      skid_r      <= final_beat;
      skid_full_r <= 1'b1;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/ecu_lane.sv =====
// One lane: registered coefficient times element, masked when the lane is unused.
`timescale 1ns / 1ps
module ecu_lane
  import ecu_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  logic  active,
  input  data_t coeff,
  input  data_t elem,
  output prod_t wprod_r,
  output data_t elem_r,
  output logic  active_r
);

  prod_t wprod_nxt;

  assign wprod_nxt = active ? prod_t'(coeff) * prod_t'(elem) : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      wprod_r  <= wprod_nxt;
      elem_r   <= elem;
      active_r <= active;
    end
  end

endmodule

// ===== rtl/core/ecu_prod_chain.sv =====
// Product chain: multiply active elements in order, round and saturate after each step.
`timescale 1ns / 1ps
module ecu_prod_chain
  import ecu_pkg::*;
(
  input  logic           clk,
  input  logic           en,
  input  in_beat_t       in_beat,
  input  logic [N_W-1:0] n,
  output res_t           res_r
);

  // stage 1
  prod_t          m1_r;
  data_t          c1_r, d1_r;
  logic [N_W-1:0] n1_r;
  // stage 2
  res_t           acc2_r;
  data_t          c2_r, d2_r;
  logic [N_W-1:0] n2_r;
  // stage 3
  prod_t          m3_r;
  res_t           acc3_r;
  data_t          d3_r;
  logic [N_W-1:0] n3_r;
  // stage 4
  res_t           acc4_r;
  data_t          d4_r;
  logic [N_W-1:0] n4_r;
  // stage 5
  prod_t          m5_r;
  res_t           acc5_r;
  logic [N_W-1:0] n5_r;

  res_t rs3, rs5, acc4_nxt, res_nxt;

  always_comb begin
    rs3 = round_sat(SUM_W'(m3_r));
    rs5 = round_sat(SUM_W'(m5_r));
    acc4_nxt = acc3_r;
    if (n3_r > N_W'(2)) begin
      acc4_nxt.val  = rs3.val;
      acc4_nxt.clip = acc3_r.clip | rs3.clip;
    end
    res_nxt = acc5_r;
    if (n5_r > N_W'(3)) begin
      res_nxt.val  = rs5.val;
      res_nxt.clip = acc5_r.clip | rs5.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= prod_t'(in_beat.elem_a) * prod_t'(in_beat.elem_b);
      c1_r   <= in_beat.elem_c;
      d1_r   <= in_beat.elem_d;
      n1_r   <= n;

      acc2_r <= round_sat(SUM_W'(m1_r));
      c2_r   <= c1_r;
      d2_r   <= d1_r;
      n2_r   <= n1_r;

      m3_r   <= prod_t'(acc2_r.val) * prod_t'(c2_r);
      acc3_r <= acc2_r;
      d3_r   <= d2_r;
      n3_r   <= n2_r;

      acc4_r <= acc4_nxt;
      d4_r   <= d3_r;
      n4_r   <= n3_r;

      m5_r   <= prod_t'(acc4_r.val) * prod_t'(d4_r);
      acc5_r <= acc4_r;
      n5_r   <= n4_r;

      res_r  <= res_nxt;
    end
  end

endmodule

// ===== rtl/core/ecu_merge.sv =====
// Merge stage: sums the lane products and finds the lane maximum, then forms the beat.
`timescale 1ns / 1ps
module ecu_merge
  import ecu_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  op_mode_t             mode,
  input  prod_t                wprod [NUM_LANES],
  input  data_t                elem  [NUM_LANES],
  input  logic [NUM_LANES-1:0] active,
  output out_beat_t            beat_r
);

  sum_t     sum_nxt, sum_r;
  data_t    max_nxt, max_r;
  op_mode_t mode_r;
  res_t     sum_res;
  out_beat_t beat_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum_nxt = sum_nxt + SUM_W'(wprod[i]);
    end
    max_nxt = elem[0];
    for (int i = 1; i < NUM_LANES; i++) begin
      if (active[i] && (elem[i] > max_nxt)) begin
        max_nxt = elem[i];
      end
    end
  end

  always_comb begin
    sum_res  = round_sat(sum_r);
    beat_nxt = '0;
    unique case (mode_r)
      MODE_SUM: begin
        beat_nxt.combined = sum_res.val;
        beat_nxt.clipped  = sum_res.clip;
      end
      MODE_MAX: beat_nxt.combined = max_r;
      MODE_BAD: beat_nxt.bad_mode = 1'b1;
      MODE_PROD: beat_nxt = '0;  // filled from the product chain later
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sum_nxt;
      max_r  <= max_nxt;
      mode_r <= mode;
      beat_r <= beat_nxt;
    end
  end

endmodule

// ===== sim/eltwise_combine_unit_top_tb.sv =====
// Self-checking testbench for the elementwise combine unit: directed corners, then random beats.
`timescale 1ns / 1ps
module eltwise_combine_unit_top_tb;
  import ecu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SEGMENTS    = 24;
  localparam int unsigned SEG_BEATS   = 48;

  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_RSVD6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RSVD7 = 3'd7;

  localparam data_t Q_ONE  = 16'sh0100;
  localparam data_t Q_HALF = 16'sh0080;
  localparam data_t Q_LSBN = 16'shFFFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  // mirror of the block's registers
  op_mode_t       mode_q = MODE_SUM;
  logic [N_W-1:0] n_q = N_MIN;
  data_t          coef_q[NUM_LANES] = '{COEFF_ONE, COEFF_ONE, COEFF_ONE, COEFF_ONE};

  in_beat_t    elem_feed_q[$];
  out_beat_t   combined_due_q[$];
  int unsigned tx_idle_pct = 14;
  int unsigned rx_idle_pct = 80;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  eltwise_combine_unit_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Q16.16 -> Q8.8, halves round up, clamp to 16 bits
  function automatic res_t q8_round_sat(input longint raw);
    longint t;
    res_t   r;
    t = (raw + 128) >>> FRAC_W;
    r.clip = (t > longint'(DATA_MAX)) || (t < longint'(DATA_MIN));
    if (t > longint'(DATA_MAX)) begin
      r.val = DATA_MAX;
    end else if (t < longint'(DATA_MIN)) begin
      r.val = DATA_MIN;
    end else begin
      r.val = data_t'(t[DATA_W-1:0]);
    end
    return r;
  endfunction

  function automatic out_beat_t combine_elems(input in_beat_t b);
    data_t       x[NUM_LANES];
    int unsigned n;
    longint      acc;
    res_t        step;
    data_t       best;
    out_beat_t   r;
    x[0] = b.elem_a;
    x[1] = b.elem_b;
    x[2] = b.elem_c;
    x[3] = b.elem_d;
    n = n_q;
    if (n < N_MIN) n = N_MIN;
    if (n > N_MAX) n = N_MAX;
    r = '0;
    case (mode_q)
      MODE_PROD: begin
        acc = x[0];
        for (int i = 1; i < n; i++) begin
          step = q8_round_sat(acc * longint'(x[i]));
          acc = step.val;
          r.clipped |= step.clip;
        end
        r.combined = data_t'(acc[DATA_W-1:0]);
      end
      MODE_SUM: begin
        acc = 0;
        for (int i = 0; i < n; i++) acc += longint'(coef_q[i]) * longint'(x[i]);
        step = q8_round_sat(acc);
        r.combined = step.val;
        r.clipped = step.clip;
      end
      MODE_MAX: begin
        best = x[0];
        for (int i = 1; i < n; i++) if (x[i] > best) best = x[i];
        r.combined = best;
      end
      default: r.bad_mode = 1'b1;
    endcase
    return r;
  endfunction

  // input side: one beat in flight on the bus, fed from elem_feed_q
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) combined_due_q.push_back(combine_elems(in_data));
      if (!in_valid || !in_stall) begin
        if (elem_feed_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= elem_feed_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: compare every accepted beat against the oldest prediction
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (combined_due_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result beat, expected none, got %h/%b/%b", $realtime,
                   out_data.combined, out_data.clipped, out_data.bad_mode);
        end else begin
          want = combined_due_q.pop_front();
          if (out_data.combined !== want.combined || out_data.clipped !== want.clipped ||
              out_data.bad_mode !== want.bad_mode) begin
            mismatch_cnt++;
            $display("%0t: combined exp %h got %h, clipped exp %b got %b, bad_mode exp %b got %b",
                     $realtime, want.combined, out_data.combined, want.clipped,
                     out_data.clipped, want.bad_mode, out_data.bad_mode);
          end
        end
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OP_MODE:    mode_q = op_mode_t'(val[1:0]);
      REG_NUM_INPUTS: n_q = val[N_W-1:0];
      REG_COEFF_A, REG_COEFF_B, REG_COEFF_C, REG_COEFF_D:
        coef_q[idx - REG_COEFF_A] = data_t'(val);
      default: ;
    endcase
  endtask

  task automatic set_regs(input op_mode_t m, input logic [N_W-1:0] n, input data_t ca,
                          input data_t cb, input data_t cc, input data_t cd);
    write_reg(REG_OP_MODE, DATA_W'(m));
    write_reg(REG_NUM_INPUTS, DATA_W'(n));
    write_reg(REG_COEFF_A, ca);
    write_reg(REG_COEFF_B, cb);
    write_reg(REG_COEFF_C, cc);
    write_reg(REG_COEFF_D, cd);
  endtask

  task automatic push_elems(input data_t a, input data_t b, input data_t c, input data_t d);
    in_beat_t beat;
    beat.elem_a = a;
    beat.elem_b = b;
    beat.elem_c = c;
    beat.elem_d = d;
    elem_feed_q.push_back(beat);
  endtask

  // wait until every beat has gone through, then let the pipeline settle
  task automatic drain_block();
    do @(posedge clk);
    while (elem_feed_q.size() != 0 || in_valid || combined_due_q.size() != 0);
    repeat (PIPE_D + 2) @(posedge clk);
  endtask

  // mix of full-range, near-unity and corner values so products do not always saturate
  function automatic data_t rand_elem();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return data_t'($urandom_range(16'hFFFF));
    if (pick < 85) return data_t'(int'($urandom_range(16'h0600)) - 16'sh0300);
    case ($urandom_range(5))
      0:       return DATA_MAX;
      1:       return DATA_MIN;
      2:       return Q_ONE;
      3:       return Q_LSBN;
      4:       return Q_HALF;
      default: return '0;
    endcase
  endfunction

  initial begin
    op_mode_t       m;
    logic [N_W-1:0] n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: weighted sum of two, unit weights
    push_elems('0, '0, '0, '0);
    push_elems(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
    push_elems(DATA_MIN, DATA_MIN, DATA_MAX, DATA_MAX);
    push_elems(Q_ONE, Q_HALF, DATA_MIN, '0);
    push_elems(Q_LSBN, 16'sh0001, DATA_MAX, DATA_MIN);
    drain_block();

    set_regs(MODE_PROD, 3'd4, COEFF_ONE, COEFF_ONE, COEFF_ONE, COEFF_ONE);
    push_elems(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
    push_elems(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
    push_elems(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    push_elems(Q_HALF, Q_HALF, Q_HALF, Q_HALF);
    push_elems(Q_LSBN, Q_HALF, Q_ONE, Q_ONE);
    push_elems(DATA_MIN, Q_ONE, Q_ONE, Q_LSBN);
    drain_block();

    set_regs(MODE_MAX, 3'd3, DATA_MIN, DATA_MAX, '0, Q_LSBN);
    push_elems(DATA_MIN, DATA_MAX, 16'sh1234, '0);
    push_elems(DATA_MIN, DATA_MIN, 16'sh8001, DATA_MAX);
    drain_block();

    // count below the minimum acts as two, above the maximum as four
    write_reg(REG_NUM_INPUTS, '0);
    push_elems('0, '0, DATA_MAX, DATA_MAX);
    drain_block();
    write_reg(REG_NUM_INPUTS, 16'h0007);
    push_elems('0, '0, '0, DATA_MAX);
    drain_block();

    write_reg(REG_OP_MODE, DATA_W'(MODE_BAD));
    push_elems(16'sh1234, DATA_MAX, DATA_MIN, Q_ONE);
    drain_block();

    // writes past the register list are dropped; weights at the extremes
    set_regs(MODE_SUM, 3'd4, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
    write_reg(REG_RSVD6, 16'hFFFF);
    write_reg(REG_RSVD7, 16'h0000);
    push_elems(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
    drain_block();
    set_regs(MODE_SUM, 3'd4, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
    push_elems(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
    push_elems(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN);
    drain_block();

    for (int s = 0; s < SEGMENTS; s++) begin
      if (s < SEGMENTS / 3) begin
        tx_idle_pct = 14;
        rx_idle_pct = 80;
      end else if (s < 2 * SEGMENTS / 3) begin
        tx_idle_pct = 80;
        rx_idle_pct = 14;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(9))
        0, 1, 2: m = MODE_PROD;
        3, 4, 5: m = MODE_SUM;
        6, 7, 8: m = MODE_MAX;
        default: m = MODE_BAD;
      endcase
      n = ($urandom_range(3) == 0) ? N_W'($urandom_range(7)) : N_W'($urandom_range(4, 2));
      if (s % 6 == 5)
        set_regs(m, n, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX);
      else
        set_regs(m, n, rand_elem(), rand_elem(), rand_elem(), rand_elem());
      if ($urandom_range(3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(7, 6)), DATA_W'($urandom_range(16'hFFFF)));
      for (int k = 0; k < SEG_BEATS; k++)
        push_elems(rand_elem(), rand_elem(), rand_elem(), rand_elem());
      drain_block();
    end

    repeat (PIPE_D + 4) @(posedge clk);
    if (mismatch_cnt == 0 && combined_due_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
